@@ sv/mfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mfd_pkg
// Types, constants and the CRC-32 byte update shared by the frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

  localparam int unsigned HeaderBytes  = 30;
  localparam int unsigned PayloadStart = 26;
  localparam int unsigned PosSat       = 256;
  localparam int unsigned IdCount      = 6;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_LEN_ERR   = 2'd2,
    STATUS_CRC_ERR   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [31:0] message_id;
    logic [7:0]  message_type;
    logic [31:0] hops;
    logic [31:0] sender;
    logic [31:0] receiver;
    logic [31:0] origin;
    logic [31:0] via;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/mesh_frame_deframer_crc32.sv @@
// ----------------------------------------------------------------------------
// mesh_frame_deframer_crc32
// Length-prefixed frame parser with CRC-32 check, one byte per word.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per word (rx_byte_i), frame_end_i set on the
// last byte. Output channel: one word per payload byte (result_kind_o = 0)
// and one summary word at the end of each frame (result_kind_o = 1) with
// the header fields and frame_status_o (ok, too short, length mismatch,
// CRC mismatch). Header and checksum bytes give no output word.
// Throughput: one byte per cycle while in_ready_o is high; the CRC update,
// field capture and status check for a byte all settle in the cycle it is
// accepted. A result appears on the output register in the cycle after its
// byte is accepted.
// Stall: in_ready_o stays high while the output register is empty or being
// drained; while the receiver holds out_ready_i low with a word pending,
// in_ready_o drops and input is held off.
// Reset: clears the frame state (position, length, CRC to all ones, fields)
// and empties the output register; the first byte after reset starts a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mesh_frame_deframer_crc32
  import mfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [1:0]       frame_status_o,
  output logic [31:0]      message_id_o,
  output logic [7:0]       message_type_o,
  output logic [31:0]      hops_o,
  output logic [31:0]      sender_o,
  output logic [31:0]      receiver_o,
  output logic [31:0]      origin_o,
  output logic [31:0]      via_o
);

  logic [8:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] chk_q, chk_d;
  logic [31:0] id_q [IdCount];
  logic [31:0] id_d [IdCount];
  logic [7:0]  type_q, type_d;

  logic        accept;
  logic        payload;
  logic [9:0]  pos_ext;
  logic [9:0]  len_ext;
  logic [4:0]  hdr_off;
  logic [2:0]  id_sel;
  logic [1:0]  id_lane;
  logic [1:0]  chk_lane;
  status_e     status;
  result_t     res;
  logic        free;
  result_t     out_data;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = free;

  always_comb begin
    len_d    = (pos_q == 9'd0) ? rx_byte_i : len_q;
    pos_ext  = {1'b0, pos_q};
    len_ext  = {2'b00, len_d};
    crc_d    = crc_q;
    chk_d    = chk_q;
    type_d   = type_q;
    id_d     = id_q;
    payload  = 1'b0;
    hdr_off  = 5'(pos_q - 9'd6);
    id_sel   = 3'(3'd1 + hdr_off[4:2]);
    id_lane  = 2'(pos_q[1:0] - 2'd1);
    chk_lane = 2'(pos_q[1:0] - len_d[1:0]);

    if (pos_q == 9'd0 || (pos_ext + 10'd4) < len_ext) begin
      crc_d = crc_byte(crc_q, rx_byte_i);
    end

    if (pos_q >= 9'd1 && pos_q <= 9'd4) begin
      id_d[0][{id_lane, 3'b000} +: 8] = rx_byte_i;
    end else if (pos_q == 9'd5) begin
      type_d = rx_byte_i;
    end else if (pos_q >= 9'd6 && pos_q < 9'(PayloadStart)) begin
      id_d[id_sel][{hdr_off[1:0], 3'b000} +: 8] = rx_byte_i;
    end else if (pos_q >= 9'(PayloadStart) && len_d >= 8'(HeaderBytes)) begin
      if ((pos_ext + 10'd4) < len_ext) begin
        payload = 1'b1;
      end else if (pos_ext < len_ext) begin
        chk_d[{chk_lane, 3'b000} +: 8] = chk_q[{chk_lane, 3'b000} +: 8] | rx_byte_i;
      end
    end

    pos_d = (pos_q < 9'(PosSat)) ? 9'(pos_q + 9'd1) : pos_q;
  end

  always_comb begin
    priority if (pos_d < 9'(HeaderBytes)) begin
      status = STATUS_SHORT;
    end else if ({1'b0, len_d} != pos_d) begin
      status = STATUS_LEN_ERR;
    end else if ((crc_d ^ CrcInit) != chk_d) begin
      status = STATUS_CRC_ERR;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    res = '0;
    if (frame_end_i) begin
      res.kind         = KIND_SUMMARY;
      res.status       = status;
      res.message_id   = id_d[0];
      res.message_type = type_d;
      res.hops         = id_d[1];
      res.sender       = id_d[2];
      res.receiver     = id_d[3];
      res.origin       = id_d[4];
      res.via          = id_d[5];
    end else begin
      res.kind         = KIND_PAYLOAD;
      res.status       = STATUS_OK;
      res.payload_byte = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      crc_q  <= CrcInit;
      chk_q  <= '0;
      type_q <= '0;
      for (int i = 0; i < IdCount; i++) begin
        id_q[i] <= '0;
      end
    end else if (accept) begin
      if (frame_end_i) begin
        pos_q  <= '0;
        len_q  <= '0;
        crc_q  <= CrcInit;
        chk_q  <= '0;
        type_q <= '0;
        for (int i = 0; i < IdCount; i++) begin
          id_q[i] <= '0;
        end
      end else begin
        pos_q  <= pos_d;
        len_q  <= len_d;
        crc_q  <= crc_d;
        chk_q  <= chk_d;
        type_q <= type_d;
        id_q   <= id_d;
      end
    end
  end

  mfd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && (frame_end_i || payload)),
    .data_i  (res),
    .free_o  (free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign result_kind_o  = out_data.kind;
  assign payload_byte_o = out_data.payload_byte;
  assign frame_status_o = out_data.status;
  assign message_id_o   = out_data.message_id;
  assign message_type_o = out_data.message_type;
  assign hops_o         = out_data.hops;
  assign sender_o       = out_data.sender;
  assign receiver_o     = out_data.receiver;
  assign origin_o       = out_data.origin;
  assign via_o          = out_data.via;

endmodule

`default_nettype wire

@@ sv/mfd_out_stage.sv @@
// ----------------------------------------------------------------------------
// mfd_out_stage
// Result register with valid/ready handshake; refills while the word drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfd_out_stage
  import mfd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t data_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ sim/mfd_result_checker.sv @@
// ----------------------------------------------------------------------------
// mfd_result_checker
// Watches both channels of the frame deframer, predicts the payload and
// summary words from the accepted bytes, and compares every output word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfd_result_checker
  import mfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_end_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        result_kind_i,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic [1:0]  frame_status_i,
  input  wire logic [31:0] message_id_i,
  input  wire logic [7:0]  message_type_i,
  input  wire logic [31:0] hops_i,
  input  wire logic [31:0] sender_i,
  input  wire logic [31:0] receiver_i,
  input  wire logic [31:0] origin_i,
  input  wire logic [31:0] via_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  logic [8:0]  byte_pos;
  logic [7:0]  frame_len;
  logic [31:0] crc_acc;
  logic [31:0] check_rx;
  logic [31:0] id_word [IdCount];
  logic [7:0]  type_byte;

  result_t     expected_words[$];
  result_t     want;
  int unsigned fails = 0;

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  task automatic restart_frame();
    byte_pos  = '0;
    frame_len = '0;
    crc_acc   = CrcInit;
    check_rx  = '0;
    type_byte = '0;
    for (int i = 0; i < IdCount; i++) begin
      id_word[i] = '0;
    end
  endtask

  task automatic predict_word(input logic [7:0] b, input logic last);
    int unsigned p;
    int unsigned len;
    int unsigned n;
    logic        carry_payload;
    result_t     r;
    p = byte_pos;
    if (p == 0) begin
      frame_len = b;
    end
    len = frame_len;
    if (p == 0 || p + 4 < len) begin
      crc_acc = crc_update(crc_acc, b);
    end
    carry_payload = 1'b0;
    if (p >= 1 && p <= 4) begin
      id_word[0] = id_word[0] | (32'(b) << (8 * (p - 1)));
    end else if (p == 5) begin
      type_byte = b;
    end else if (p >= 6 && p < PayloadStart) begin
      id_word[1 + (p - 6) / 4] = id_word[1 + (p - 6) / 4] | (32'(b) << (8 * ((p - 6) % 4)));
    end else if (p >= PayloadStart && len >= HeaderBytes) begin
      if (p + 4 < len) begin
        carry_payload = 1'b1;
      end else if (p < len) begin
        check_rx = check_rx | (32'(b) << (8 * ((p + 4 - len) % 4)));
      end
    end
    if (byte_pos < PosSat) begin
      byte_pos = byte_pos + 9'd1;
    end
    r = '0;
    if (last) begin
      n = byte_pos;
      r.kind = KIND_SUMMARY;
      if (n < HeaderBytes) begin
        r.status = STATUS_SHORT;
      end else if (len != n) begin
        r.status = STATUS_LEN_ERR;
      end else if (~crc_acc != check_rx) begin
        r.status = STATUS_CRC_ERR;
      end else begin
        r.status = STATUS_OK;
      end
      r.message_id   = id_word[0];
      r.message_type = type_byte;
      r.hops         = id_word[1];
      r.sender       = id_word[2];
      r.receiver     = id_word[3];
      r.origin       = id_word[4];
      r.via          = id_word[5];
      expected_words.push_back(r);
      restart_frame();
    end else if (carry_payload) begin
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = b;
      expected_words.push_back(r);
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_frame();
      expected_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %0d", $time,
                   result_kind_i);
          fails++;
        end else begin
          want = expected_words.pop_front();
          report_field("result_kind", 32'(want.kind), 32'(result_kind_i));
          report_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_i));
          report_field("frame_status", 32'(want.status), 32'(frame_status_i));
          report_field("message_id", want.message_id, message_id_i);
          report_field("message_type", 32'(want.message_type), 32'(message_type_i));
          report_field("hops", want.hops, hops_i);
          report_field("sender", want.sender, sender_i);
          report_field("receiver", want.receiver, receiver_i);
          report_field("origin", want.origin, origin_i);
          report_field("via", want.via, via_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_word(rx_byte_i, frame_end_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_words.size();
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives received frames into the deframer byte by byte: a few short frames
// first, then random good, corrupted, truncated, padded, short and overlong
// frames with random idle and stall cycles on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import mfd_pkg::*;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = 8'h00;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [1:0]  frame_status;
  logic [31:0] message_id;
  logic [7:0]  message_type;
  logic [31:0] hops;
  logic [31:0] sender;
  logic [31:0] receiver;
  logic [31:0] origin;
  logic [31:0] via;
  int unsigned fail_count;
  int unsigned pending;

  logic        calm        = 1'b0;
  int unsigned items_sent  = 0;
  logic [7:0]  frame_bytes[$];

  mesh_frame_deframer_crc32 u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .frame_end_i    (frame_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .payload_byte_o (payload_byte),
    .frame_status_o (frame_status),
    .message_id_o   (message_id),
    .message_type_o (message_type),
    .hops_o         (hops),
    .sender_o       (sender),
    .receiver_o     (receiver),
    .origin_o       (origin),
    .via_o          (via)
  );

  mfd_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .rx_byte_i      (rx_byte),
    .frame_end_i    (frame_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_i  (result_kind),
    .payload_byte_i (payload_byte),
    .frame_status_i (frame_status),
    .message_id_i   (message_id),
    .message_type_i (message_type),
    .hops_i         (hops),
    .sender_i       (sender),
    .receiver_i     (receiver),
    .origin_i       (origin),
    .via_i          (via),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 12);
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    frame_end <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_sent++;
    calm = (items_sent >= 400 && items_sent < 700);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      send_word(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // hold input until every expected word is out, then let the pipe settle
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic build_good(input int unsigned len);
    logic [31:0] crc;
    int unsigned fill;
    fill = $urandom_range(0, 9);
    frame_bytes.delete();
    frame_bytes.push_back(8'(len));
    for (int i = 1; i < len - 4; i++) begin
      if (fill == 0) begin
        frame_bytes.push_back(8'h00);
      end else if (fill == 1) begin
        frame_bytes.push_back(8'hFF);
      end else begin
        frame_bytes.push_back(8'($urandom));
      end
    end
    crc = CrcInit;
    foreach (frame_bytes[i]) begin
      crc = crc_byte(crc, frame_bytes[i]);
    end
    crc = ~crc;
    for (int i = 0; i < 4; i++) begin
      frame_bytes.push_back(crc[8*i +: 8]);
    end
  endtask

  task automatic fill_random(input int unsigned count);
    frame_bytes.delete();
    repeat (count) frame_bytes.push_back(8'($urandom));
  endtask

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    int unsigned idx;
    logic        drained_mid;
    drained_mid = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    frame_bytes = '{8'h00};
    send_frame();
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_frame();
    frame_bytes = '{8'h1E, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h3C};
    send_frame();
    drain_results();

    while (items_sent < 1700) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 255) : $urandom_range(30, 64);
      build_good(len);
      if (kind >= 55 && kind < 65) begin
        idx = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
      end else if (kind >= 65 && kind < 73) begin
        if ($urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
        end else begin
          cut = $urandom_range(30, len - 1);
          while (frame_bytes.size() > cut) begin
            void'(frame_bytes.pop_back());
          end
        end
      end else if (kind >= 73 && kind < 80) begin
        fill_random($urandom_range(1, 29));
      end else if (kind >= 80 && kind < 85) begin
        frame_bytes[0] = 8'($urandom_range(0, 29));
      end else if (kind >= 85 && kind < 89) begin
        cut = $urandom_range(257, 300);
        while (frame_bytes.size() < cut) begin
          frame_bytes.push_back(8'($urandom));
        end
      end else if (kind >= 89 && kind < 94) begin
        fill_random($urandom_range(1, 80));
      end
      send_frame();
      if (!drained_mid && items_sent >= 900) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
